FILE: rtl/agds_pkg.sv
// Package for the averaged gain-scheduled DAC stepper.
// Holds widths, command codes, gain constants and the item/result structs.
// No dependencies.
package agds_pkg;

  localparam int WINDOW_LOG2 = 4;
  localparam int WINDOW      = 1 << WINDOW_LOG2;
  localparam int DAC_BITS    = 16;

  localparam int SAMPLE_W  = 16;
  localparam int DAC_OUT_W = 16;
  localparam int CFG_W     = 16;
  localparam int SLOT_W    = WINDOW_LOG2;
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + WINDOW_LOG2;

  localparam int GAIN_W = 6;
  localparam int STEP_W = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W  = ((DAC_BITS + 1 > STEP_W) ? DAC_BITS + 1 : STEP_W) + 1;

  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [SAMPLE_W:0] MAG_FINE_LIMIT = (SAMPLE_W + 1)'(2);
  localparam logic [SAMPLE_W:0] MAG_MID_LIMIT  = (SAMPLE_W + 1)'(6);
  localparam logic [GAIN_W-1:0] GAIN_FINE      = GAIN_W'(2);
  localparam logic [GAIN_W-1:0] GAIN_MID       = GAIN_W'(30);
  localparam logic [GAIN_W-1:0] GAIN_COARSE    = GAIN_W'(50);

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] error_sample;
  } agds_item_t;

  typedef struct packed {
    logic [DAC_OUT_W-1:0] dac;
    logic                 ready;
  } agds_result_t;

endpackage

FILE: rtl/agds_core.sv
// Regulator state: sample window, running sum, mean, gain schedule, DAC.
// State updates on each accepted item or config write; the result is combinational from state and item.
// Depends on agds_pkg.
module agds_core
  import agds_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic         accept,
  input  agds_item_t   item,
  output agds_result_t result
);

  localparam logic signed [ACC_W-1:0] DAC_MAX_EXT = ACC_W'((64'd1 << DAC_BITS) - 64'd1);

  logic signed [SAMPLE_W-1:0] window [WINDOW];
  logic signed [SUM_W-1:0]    window_sum, sum_next, sum_adj, mean_full;
  logic [FILL_W-1:0]          fill_count, fill_next;
  logic [SLOT_W-1:0]          write_slot;
  logic signed [SAMPLE_W-1:0] averaged_error, avg_next, oldest;
  logic                       ready_flag, ready_next, full;
  logic [DAC_BITS-1:0]        drive_level, drive_next, cfg_drive;
  logic [SAMPLE_W:0]          avg_ext, mag;
  logic [GAIN_W-1:0]          gain;
  logic signed [STEP_W-1:0]   step;
  logic signed [ACC_W-1:0]    acc;

  function automatic logic [DAC_BITS-1:0] clamp_dac(logic signed [ACC_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > DAC_MAX_EXT) begin
      return DAC_MAX_EXT[DAC_BITS-1:0];
    end else begin
      return v[DAC_BITS-1:0];
    end
  endfunction

  always_comb begin
    full      = (fill_count == FILL_W'(WINDOW));
    oldest    = window[write_slot];
    sum_next  = window_sum + SUM_W'(item.error_sample) - (full ? SUM_W'(oldest) : '0);
    fill_next = full ? fill_count : fill_count + 1'b1;
    // truncate toward zero: bias negative sums before the arithmetic shift
    sum_adj   = sum_next + (sum_next[SUM_W-1] ? SUM_W'(WINDOW - 1) : '0);
    mean_full = sum_adj >>> WINDOW_LOG2;

    avg_ext = {averaged_error[SAMPLE_W-1], averaged_error};
    mag     = averaged_error[SAMPLE_W-1] ? (~avg_ext + 1'b1) : avg_ext;
    if (mag < MAG_FINE_LIMIT) begin
      gain = GAIN_FINE;
    end else if (mag <= MAG_MID_LIMIT) begin
      gain = GAIN_MID;
    end else begin
      gain = GAIN_COARSE;
    end
    step = averaged_error * $signed({1'b0, gain});
    acc  = ACC_W'($signed({1'b0, drive_level})) + ACC_W'(step);

    cfg_drive = clamp_dac(ACC_W'($signed({1'b0, cfg_data})));

    avg_next   = averaged_error;
    ready_next = ready_flag;
    drive_next = drive_level;
    unique case (item.command)
      CMD_PUSH: begin
        if (fill_next == FILL_W'(WINDOW)) begin
          avg_next   = mean_full[SAMPLE_W-1:0];
          ready_next = 1'b1;
        end
      end
      CMD_UPDATE: begin
        if (ready_flag) begin
          drive_next = clamp_dac(acc);
        end
      end
      default: ;
    endcase

    result.dac   = DAC_OUT_W'(drive_next);
    result.ready = ready_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum     <= '0;
      fill_count     <= '0;
      write_slot     <= '0;
      averaged_error <= '0;
      ready_flag     <= 1'b0;
      drive_level    <= '0;
    end else if (cfg_we) begin
      drive_level <= cfg_drive;
    end else if (accept) begin
      averaged_error <= avg_next;
      ready_flag     <= ready_next;
      drive_level    <= drive_next;
      if (item.command == CMD_PUSH) begin
        window_sum <= sum_next;
        fill_count <= fill_next;
        write_slot <= write_slot + 1'b1;
      end
    end
  end

  // window entries carry no reset; an entry is read only once written
  always_ff @(posedge clk) begin
    if (accept && !cfg_we && item.command == CMD_PUSH) begin
      window[write_slot] <= item.error_sample;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW))
    else $error("fill count beyond window depth");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> full)
    else $error("mean marked ready before window filled");

  a_ready_by_push: assert property (@(posedge clk) disable iff (rst)
    $rose(ready_flag) |-> $past(accept && item.command == CMD_PUSH))
    else $error("ready set by something other than a push");

endmodule

FILE: rtl/agds_out_q.sv
// Two-entry result queue: output register plus skid entry.
// Lets the input side keep accepting while one result waits.
// Depends on agds_pkg.
module agds_out_q
  import agds_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  agds_result_t push_data,
  output logic         full,
  output logic         head_valid,
  input  logic         pop_stall,
  output agds_result_t head
);

  logic [1:0]   count;
  logic         pop;
  agds_result_t slot1;

  assign head_valid = (count != 2'd0) && !rst;
  assign full       = (count == 2'd2);
  assign pop        = head_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        head  <= slot1;
        slot1 <= push_data;
      end else begin
        head <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop) begin
      head <= slot1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("result pushed into full queue");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && pop && !push) |=> (head == $past(slot1)))
    else $error("skid entry lost on pop");

endmodule

FILE: rtl/averaged_gain_scheduled_dac_stepper.sv
// Averaged gain-scheduled DAC stepper: the result of each input transaction is
// registered in the two-entry result queue before it reaches the output; throughput
// 1 item per cycle, set by the single state-update pass in agds_core feeding the queue.
// Input stalls when both queue entries hold undelivered results, and while a
// config write is offered. Synchronous active-high reset clears all control
// state and sets the DAC to 0; window entries are not cleared.
module averaged_gain_scheduled_dac_stepper
  import agds_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] error_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DAC_OUT_W-1:0]       dac_value,
  output logic                       mean_ready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic         accept, q_full, cfg_we;
  agds_item_t   item;
  agds_result_t result, head;

  // a config write takes the cycle; the input transaction waits for it
  assign in_stall  = q_full || rst || cfg_valid;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign item.command      = command;
  assign item.error_sample = error_sample;

  agds_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .result   (result)
  );

  agds_out_q u_out_q (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && !cfg_we),
    .push_data  (result),
    .full       (q_full),
    .head_valid (out_valid),
    .pop_stall  (out_stall),
    .head       (head)
  );

  assign dac_value  = head.dac;
  assign mean_ready = head.ready;

endmodule

FILE: dv/tb_averaged_gain_scheduled_dac_stepper.sv
// Self-checking testbench for averaged_gain_scheduled_dac_stepper.
// Clocked driver and monitor around a local model of the averaging window and the DAC steps.
// Depends on agds_pkg and the DUT RTL only.
module tb_averaged_gain_scheduled_dac_stepper
  import agds_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 2000;
  localparam int DAC_TOP     = (1 << DAC_BITS) - 1;
  localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));
  localparam int LONG_HOLD   = 80;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       command = CMD_PUSH;
  logic signed [SAMPLE_W-1:0] error_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [DAC_OUT_W-1:0]       dac_value;
  logic                       mean_ready;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_data = '0;

  averaged_gain_scheduled_dac_stepper DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .error_sample (error_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dac_value    (dac_value),
    .mean_ready   (mean_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // regulator model state
  logic signed [SAMPLE_W-1:0] win_mem [WINDOW];
  int win_sum   = 0;
  int fill_n    = 0;
  int wr_slot   = 0;
  int mean_err  = 0;
  bit mean_ok   = 1'b0;
  int dac_level = 0;

  agds_item_t   stim_items[$];
  agds_result_t dac_results[$];

  bit jitter_on = 1'b1;
  bit hold_req  = 1'b0;
  int err_cnt   = 0;
  int cyc_cnt   = 0;

  function automatic agds_result_t regulate(input logic cmd, input logic signed [SAMPLE_W-1:0] s);
    int mag;
    int gain_step;
    agds_result_t r;
    if (cmd == CMD_PUSH) begin
      if (fill_n >= WINDOW) begin
        win_sum -= win_mem[wr_slot];
      end else begin
        fill_n++;
      end
      win_mem[wr_slot] = s;
      win_sum += s;
      wr_slot = (wr_slot + 1) % WINDOW;
      if (fill_n >= WINDOW) begin
        mean_err = win_sum / WINDOW;  // truncates toward zero
        mean_ok  = 1'b1;
      end
    end else if (mean_ok) begin
      mag = (mean_err < 0) ? -mean_err : mean_err;
      if (mag < int'(MAG_FINE_LIMIT)) begin
        gain_step = mean_err * int'(GAIN_FINE);
      end else if (mag <= int'(MAG_MID_LIMIT)) begin
        gain_step = mean_err * int'(GAIN_MID);
      end else begin
        gain_step = mean_err * int'(GAIN_COARSE);
      end
      dac_level += gain_step;
      if (dac_level < 0) dac_level = 0;
      if (dac_level > DAC_TOP) dac_level = DAC_TOP;
    end
    r.dac   = dac_level[DAC_OUT_W-1:0];
    r.ready = mean_ok;
    return r;
  endfunction

  // driver: one item per transaction, random gap after each accepted one when jitter is on
  int drv_gap = 0;
  agds_item_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        dac_results.push_back(regulate(command, error_sample));
        drv_gap = jitter_on ? $urandom_range(0, 3) : 0;
      end
      if (drv_gap > 0 || stim_items.size() == 0) begin
        if (drv_gap > 0) drv_gap--;
        in_valid <= 1'b0;
      end else begin
        drv_item = stim_items.pop_front();
        in_valid     <= 1'b1;
        command      <= drv_item.command;
        error_sample <= drv_item.error_sample;
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  int mon_gap   = 0;
  int hold_left = 0;
  agds_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      mon_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dac_results.size() == 0) begin
          $error("unexpected result: dac_value %0d mean_ready %0b", dac_value, mean_ready);
          err_cnt++;
        end else begin
          want = dac_results.pop_front();
          if (dac_value !== want.dac) begin
            $error("dac_value mismatch: expected %0d, actual %0d", want.dac, dac_value);
            err_cnt++;
          end
          if (mean_ready !== want.ready) begin
            $error("mean_ready mismatch: expected %0b, actual %0b", want.ready, mean_ready);
            err_cnt++;
          end
        end
        mon_gap = jitter_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void queue_item(input logic cmd, input int s);
    agds_item_t it;
    it.command      = cmd;
    it.error_sample = s[SAMPLE_W-1:0];
    stim_items.push_back(it);
  endfunction

  function automatic int rand_sample();
    return int'($urandom_range(0, 65535)) + SAMPLE_MIN;
  endfunction

  function automatic int pick_mean();
    int sgn;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 2)) - 1;
      1:       return sgn * int'($urandom_range(2, 6));
      2:       return sgn * int'($urandom_range(7, 40));
      3:       return sgn * int'($urandom_range(41, 3000));
      4:       return (sgn > 0) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return rand_sample();
    endcase
  endfunction

  // a run of pushes around one mean, then a few corrections; sometimes noise
  function automatic int add_burst();
    int n_push;
    int n_upd;
    int spread;
    int m;
    int v;
    int cnt;
    cnt    = 0;
    m      = pick_mean();
    spread = $urandom_range(0, 3) == 0 ? int'($urandom_range(1, 4)) : 0;
    n_push = $urandom_range(0, 3) == 0 ? int'($urandom_range(1, 6)) : int'($urandom_range(16, 20));
    n_upd  = $urandom_range(0, 6);
    repeat (n_push) begin
      v = m + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      queue_item(CMD_PUSH, v);
      cnt++;
    end
    repeat (n_upd) begin
      queue_item(CMD_UPDATE, rand_sample());
      cnt++;
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        queue_item($urandom_range(0, 1) ? CMD_UPDATE : CMD_PUSH, rand_sample());
        cnt++;
      end
    end
    return cnt;
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (stim_items.size() != 0 || in_valid || dac_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_initial_dac(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // only the DAC level reloads; window and mean survive
    dac_level = int'(v);
    if (dac_level > DAC_TOP) dac_level = DAC_TOP;
  endtask

  initial begin : stimulus
    int queued;
    int phase;
    logic [CFG_W-1:0] cfg_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corrections before the window is full leave the DAC alone
    queue_item(CMD_UPDATE, SAMPLE_MAX);
    queue_item(CMD_UPDATE, SAMPLE_MIN);
    // fill the window with the sample extremes, then saturate high
    queue_item(CMD_PUSH, SAMPLE_MIN);
    repeat (15) queue_item(CMD_PUSH, SAMPLE_MAX);
    queue_item(CMD_UPDATE, 0);
    queue_item(CMD_UPDATE, -1);
    // full window: oldest entry drops out, slot wraps
    queue_item(CMD_PUSH, SAMPLE_MIN);
    queue_item(CMD_PUSH, 0);
    queue_item(CMD_PUSH, -1);
    queue_item(CMD_UPDATE, 1);
    wait_drained();

    queued = 0;
    phase  = 0;
    while (queued < ITEM_TARGET) begin
      case (phase)
        0:       cfg_pick = '1;
        1:       cfg_pick = '0;
        2:       cfg_pick = 16'h8000;
        3:       cfg_pick = 16'h5555;
        4:       cfg_pick = 16'haaaa;
        default: cfg_pick = CFG_W'($urandom_range(0, 65535));
      endcase
      write_initial_dac(cfg_pick);
      @(negedge clk);
      jitter_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (20) queued += add_burst();
      // receiver holds off while the sender keeps offering
      if (phase == 2) hold_req = 1'b1;
      wait_drained();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/agds_pkg.sv
rtl/agds_core.sv
rtl/agds_out_q.sv
rtl/averaged_gain_scheduled_dac_stepper.sv
dv/tb_averaged_gain_scheduled_dac_stepper.sv
